// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the SD card command responder.
// Standalone header; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define SDCR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define SDCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SDCR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define SDCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/sdcr_pkg.sv -----
// Package for the SD card command responder: codes, constant CID/CSD tables and
// the job descriptor passed from the front part to the back part. No dependencies.
package sdcr_pkg;

  // widths
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CMD_IDX_W  = 6;
  localparam int unsigned ARG_W      = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned RCA_W      = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned LIST_BYTES = 6;
  localparam int unsigned LIST_IDX_W = 3;
  localparam int unsigned TBL_IDX_W  = 4;

  localparam int unsigned MAX_BLOCK_LENGTH = 4096;
  localparam logic [LEN_W-1:0] RESET_BLOCK_LENGTH = 13'd512;
  localparam logic [RCA_W-1:0] CARD_RCA_VALUE     = 16'd1;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input actions
  localparam logic [ACTION_W-1:0] ACT_CMD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

  // response formats
  localparam logic [FMT_W-1:0] FMT_R1   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_R1B  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_R2   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_R3   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_R6   = 3'd4;
  localparam logic [FMT_W-1:0] FMT_R7   = 3'd5;
  localparam logic [FMT_W-1:0] FMT_NONE = 3'd6;

  // command indexes
  localparam logic [CMD_IDX_W-1:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [CMD_IDX_W-1:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [CMD_IDX_W-1:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [CMD_IDX_W-1:0] CMD_SELECT       = 6'd7;
  localparam logic [CMD_IDX_W-1:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [CMD_IDX_W-1:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [CMD_IDX_W-1:0] CMD_STOP         = 6'd12;
  localparam logic [CMD_IDX_W-1:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [CMD_IDX_W-1:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [CMD_IDX_W-1:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [CMD_IDX_W-1:0] CMD_APP          = 6'd55;
  localparam logic [CMD_IDX_W-1:0] ACMD_OP_COND     = 6'd41;
  localparam logic [CMD_IDX_W-1:0] ACMD_SEND_SCR    = 6'd51;

  // response byte constants
  localparam logic [BYTE_W-1:0] REG_HEADER   = 8'h3F;
  localparam logic [BYTE_W-1:0] R7_HEADER    = 8'h48;
  localparam logic [BYTE_W-1:0] R1B_HEADER   = 8'hC7;
  localparam logic [BYTE_W-1:0] R6_HEADER    = 8'h03;
  localparam logic [BYTE_W-1:0] RESP_TRAILER = 8'h01;
  localparam logic [BYTE_W-1:0] OCR_FILL     = 8'hFF;
  localparam logic [CNT_W-1:0]  REG_RESP_LEN = 5'd17;

  localparam logic [0:15][BYTE_W-1:0] CSD_TABLE = {
    8'h40, 8'h0e, 8'h00, 8'h32, 8'h5b, 8'h59, 8'h00, 8'h00,
    8'h1d, 8'h6f, 8'h7f, 8'h80, 8'h0a, 8'h40, 8'h00, 8'h00
  };
  localparam logic [0:15][BYTE_W-1:0] CID_TABLE = {
    8'h02, 8'h54, 8'h4d, 8'h53, 8'h41, 8'h30, 8'h34, 8'h47,
    8'h06, 8'h23, 8'h65, 8'hd7, 8'hfd, 8'h00, 8'hb2, 8'h00
  };

  // where the back part takes response bytes from
  typedef enum logic [1:0] {
    SRC_LIST = 2'd0,
    SRC_CID  = 2'd1,
    SRC_CSD  = 2'd2
  } src_t;

  // one classified item, ready to be played out
  typedef struct packed {
    logic [KIND_W-1:0]               kind;
    logic [FMT_W-1:0]                fmt;
    src_t                            src;
    logic [CNT_W-1:0]                count;
    logic [0:LIST_BYTES-1][BYTE_W-1:0] bytes;
    logic                            err;
    logic [ARG_W-1:0]                addr;
    logic [LEN_W-1:0]                len;
    logic                            ok;
    logic                            sel;
  } desc_t;

  // handshake between the job queue and its users
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ----- rtl/sdcr_queue.sv -----
// Short job queue between the front and back parts of the SD command responder.
// Depends on sdcr_pkg for the descriptor type and queue depth.
module sdcr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sdcr_pkg::q_ctrl_t ctrl,
  input  sdcr_pkg::desc_t  push_data,
  output sdcr_pkg::q_stat_t stat,
  output sdcr_pkg::desc_t  pop_data
);

  sdcr_pkg::desc_t                   mem_r [sdcr_pkg::QUEUE_DEPTH];
  logic [sdcr_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sdcr_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sdcr_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign stat.full  = (cnt_r == sdcr_pkg::QCNT_W'(sdcr_pkg::QUEUE_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && stat.valid;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sdcr_pkg::QPTR_W'(sdcr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sdcr_pkg::QPTR_W'(sdcr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/sdcr_front.sv -----
// Front part of the SD command responder: accepts items, updates card state and
// classifies each item into a job descriptor. Depends on sdcr_pkg.
module sdcr_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sdcr_pkg::ACTION_W-1:0]      in_action,
  input  logic [sdcr_pkg::CMD_IDX_W-1:0]     in_cmd_index,
  input  logic [sdcr_pkg::ARG_W-1:0]         in_cmd_arg,
  input  sdcr_pkg::q_stat_t                  q_stat,
  output logic                               q_push,
  output sdcr_pkg::desc_t                    q_data
);

  logic                            reading_r, reading_nxt;
  logic                            line_busy_r, line_busy_nxt;
  logic                            app_pending_r, app_pending_nxt;
  logic [sdcr_pkg::RCA_W-1:0]      card_rca_r, card_rca_nxt;
  logic                            card_sel_r, card_sel_nxt;
  logic [sdcr_pkg::LEN_W-1:0]      block_len_r, block_len_nxt;
  logic [sdcr_pkg::ARG_W-1:0]      read_addr_r, read_addr_nxt;
  logic                            single_r, single_nxt;
  logic                            in_acc;
  logic                            push;
  sdcr_pkg::desc_t                 d;

  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = in_acc && push;
  assign q_data   = d;

  // decode and next state
  always_comb begin
    reading_nxt     = reading_r;
    line_busy_nxt   = line_busy_r;
    app_pending_nxt = app_pending_r;
    card_rca_nxt    = card_rca_r;
    card_sel_nxt    = card_sel_r;
    block_len_nxt   = block_len_r;
    read_addr_nxt   = read_addr_r;
    single_nxt      = single_r;
    push            = 1'b0;
    d.kind          = sdcr_pkg::KIND_EMPTY;
    d.fmt           = sdcr_pkg::FMT_NONE;
    d.src           = sdcr_pkg::SRC_LIST;
    d.count         = sdcr_pkg::CNT_W'(1);
    d.bytes         = '0;
    d.err           = 1'b0;
    d.addr          = '0;
    d.len           = '0;
    d.ok            = 1'b0;

    if (in_action == sdcr_pkg::ACT_CMD) begin
      push            = 1'b1;
      app_pending_nxt = 1'b0;
      if (app_pending_r) begin
        // application command after CMD55
        if (in_cmd_index == sdcr_pkg::ACMD_OP_COND ||
            in_cmd_index == sdcr_pkg::ACMD_SEND_SCR) begin
          d.kind  = sdcr_pkg::KIND_BYTE;
          d.fmt   = sdcr_pkg::FMT_R3;
          d.count = sdcr_pkg::CNT_W'(6);
          d.bytes = {sdcr_pkg::REG_HEADER, {5{sdcr_pkg::OCR_FILL}}};
        end else begin
          d.err = 1'b1;
        end
      end else begin
        case (in_cmd_index)
          sdcr_pkg::CMD_GO_IDLE: begin
            reading_nxt   = 1'b0;
            line_busy_nxt = 1'b0;
            d.fmt         = sdcr_pkg::FMT_R1;
          end
          sdcr_pkg::CMD_ALL_SEND_CID: begin
            d.kind  = sdcr_pkg::KIND_BYTE;
            d.fmt   = sdcr_pkg::FMT_R2;
            d.src   = sdcr_pkg::SRC_CID;
            d.count = sdcr_pkg::REG_RESP_LEN;
          end
          sdcr_pkg::CMD_SEND_RCA: begin
            card_rca_nxt = sdcr_pkg::CARD_RCA_VALUE;
            d.kind  = sdcr_pkg::KIND_BYTE;
            d.fmt   = sdcr_pkg::FMT_R6;
            d.count = sdcr_pkg::CNT_W'(5);
            d.bytes = {sdcr_pkg::R6_HEADER, sdcr_pkg::CARD_RCA_VALUE, 8'h00,
                       sdcr_pkg::RESP_TRAILER, 8'h00};
          end
          sdcr_pkg::CMD_SELECT: begin
            card_sel_nxt = (in_cmd_arg == {16'h0000, card_rca_r}) && (in_cmd_arg != '0);
            d.kind  = sdcr_pkg::KIND_BYTE;
            d.fmt   = sdcr_pkg::FMT_R1B;
            d.count = sdcr_pkg::CNT_W'(5);
            d.bytes = {sdcr_pkg::R1B_HEADER, 8'h00, 8'h00, 8'h00,
                       sdcr_pkg::RESP_TRAILER, 8'h00};
          end
          sdcr_pkg::CMD_SEND_IF_COND: begin
            // echo voltage nibble and check pattern
            d.kind  = sdcr_pkg::KIND_BYTE;
            d.fmt   = sdcr_pkg::FMT_R7;
            d.count = sdcr_pkg::CNT_W'(6);
            d.bytes = {sdcr_pkg::R7_HEADER, 8'h00, 8'h00, 4'h0, in_cmd_arg[11:8],
                       in_cmd_arg[7:0], sdcr_pkg::RESP_TRAILER};
          end
          sdcr_pkg::CMD_SEND_CSD: begin
            d.kind  = sdcr_pkg::KIND_BYTE;
            d.fmt   = sdcr_pkg::FMT_R2;
            d.src   = sdcr_pkg::SRC_CSD;
            d.count = sdcr_pkg::REG_RESP_LEN;
          end
          sdcr_pkg::CMD_STOP: begin
            reading_nxt = 1'b0;
          end
          sdcr_pkg::CMD_SET_BLOCKLEN: begin
            if (in_cmd_arg > sdcr_pkg::ARG_W'(sdcr_pkg::MAX_BLOCK_LENGTH)) begin
              d.err = 1'b1;
            end else begin
              block_len_nxt = in_cmd_arg[sdcr_pkg::LEN_W-1:0];
            end
          end
          sdcr_pkg::CMD_READ_SINGLE: begin
            read_addr_nxt = in_cmd_arg;
            reading_nxt   = 1'b1;
            single_nxt    = 1'b1;
          end
          sdcr_pkg::CMD_READ_MULTI: begin
            read_addr_nxt = in_cmd_arg;
            reading_nxt   = 1'b1;
            single_nxt    = 1'b0;
          end
          sdcr_pkg::CMD_APP: begin
            app_pending_nxt = 1'b1;
            d.fmt           = sdcr_pkg::FMT_R1;
          end
          default: begin
            d.err = 1'b1;
          end
        endcase
      end
    end else if (in_action == sdcr_pkg::ACT_TICK) begin
      // block fetch when reading and the data line is free
      if (reading_r && !line_busy_r) begin
        push          = 1'b1;
        d.kind        = sdcr_pkg::KIND_FETCH;
        d.addr        = read_addr_r;
        d.len         = block_len_r;
        line_busy_nxt = 1'b1;
        read_addr_nxt = read_addr_r + {{(sdcr_pkg::ARG_W - sdcr_pkg::LEN_W){1'b0}}, block_len_r};
        if (single_r) begin
          reading_nxt = 1'b0;
        end
      end
    end else if (in_action == sdcr_pkg::ACT_READ) begin
      push          = 1'b1;
      d.kind        = sdcr_pkg::KIND_STATUS;
      d.len         = line_busy_r ? block_len_r : '0;
      d.ok          = line_busy_r;
      line_busy_nxt = 1'b0;
    end
    d.sel = card_sel_nxt;
  end

  // card state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r     <= 1'b0;
      line_busy_r   <= 1'b0;
      app_pending_r <= 1'b0;
      card_rca_r    <= '0;
      card_sel_r    <= 1'b0;
      block_len_r   <= sdcr_pkg::RESET_BLOCK_LENGTH;
      read_addr_r   <= '0;
      single_r      <= 1'b0;
    end else if (in_acc) begin
      reading_r     <= reading_nxt;
      line_busy_r   <= line_busy_nxt;
      app_pending_r <= app_pending_nxt;
      card_rca_r    <= card_rca_nxt;
      card_sel_r    <= card_sel_nxt;
      block_len_r   <= block_len_nxt;
      read_addr_r   <= read_addr_nxt;
      single_r      <= single_nxt;
    end
  end

endmodule

// ----- rtl/sdcr_back.sv -----
// Back part of the SD command responder: plays out each queued job as one or more
// result items through an output register. Depends on sdcr_pkg.
module sdcr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sdcr_pkg::q_stat_t               q_stat,
  input  sdcr_pkg::desc_t                 q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdcr_pkg::KIND_W-1:0]     out_kind,
  output logic [sdcr_pkg::FMT_W-1:0]      out_resp_format,
  output logic [sdcr_pkg::BYTE_W-1:0]     out_resp_byte,
  output logic                            out_last,
  output logic                            out_error,
  output logic [sdcr_pkg::ARG_W-1:0]      out_fetch_address,
  output logic [sdcr_pkg::LEN_W-1:0]      out_fetch_length,
  output logic                            out_read_ok,
  output logic                            out_selected
);

  sdcr_pkg::desc_t                 cur_r;
  logic                            cur_v_r, cur_v_nxt;
  logic [sdcr_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sdcr_pkg::KIND_W-1:0]     kind_r;
  logic [sdcr_pkg::FMT_W-1:0]      fmt_r;
  logic [sdcr_pkg::BYTE_W-1:0]     byte_r, byte_nxt;
  logic                            last_r;
  logic                            err_r;
  logic [sdcr_pkg::ARG_W-1:0]      addr_r;
  logic [sdcr_pkg::LEN_W-1:0]      len_r;
  logic                            ok_r;
  logic                            sel_r;
  logic                            adv;
  logic                            cur_last;
  logic [sdcr_pkg::TBL_IDX_W-1:0]  tbl_idx;
  logic [sdcr_pkg::CNT_W-1:0]      idx_m1;

  assign cur_last = (idx_r == cur_r.count - 1'b1);
  assign adv      = cur_v_r && (!out_valid_r || !out_stall);
  assign q_pop    = q_stat.valid && (!cur_v_r || (adv && cur_last));
  assign idx_m1   = idx_r - 1'b1;
  assign tbl_idx  = idx_m1[sdcr_pkg::TBL_IDX_W-1:0];

  // byte for the current position: register header then table, or the list
  always_comb begin
    case (cur_r.src)
      sdcr_pkg::SRC_CID: byte_nxt = (idx_r == '0) ? sdcr_pkg::REG_HEADER
                                    : sdcr_pkg::CID_TABLE[tbl_idx];
      sdcr_pkg::SRC_CSD: byte_nxt = (idx_r == '0) ? sdcr_pkg::REG_HEADER
                                    : sdcr_pkg::CSD_TABLE[tbl_idx];
      default:           byte_nxt = cur_r.bytes[idx_r[sdcr_pkg::LIST_IDX_W-1:0]];
    endcase
  end

  // job sequencing
  always_comb begin
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (adv) begin
      idx_nxt = idx_r + 1'b1;
      if (cur_last) begin
        cur_v_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = '0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r     <= cur_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // current job and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (adv) begin
      kind_r <= cur_r.kind;
      fmt_r  <= cur_r.fmt;
      byte_r <= byte_nxt;
      last_r <= cur_last;
      err_r  <= cur_r.err;
      addr_r <= cur_r.addr;
      len_r  <= cur_r.len;
      ok_r   <= cur_r.ok;
      sel_r  <= cur_r.sel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_resp_format   = fmt_r;
  assign out_resp_byte     = byte_r;
  assign out_last          = last_r;
  assign out_error         = err_r;
  assign out_fetch_address = addr_r;
  assign out_fetch_length  = len_r;
  assign out_read_ok       = ok_r;
  assign out_selected      = sel_r;

endmodule

// ----- rtl/sd_card_command_responder.sv -----
// SD card command responder, card side. An accepted item is decoded combinationally
// and leaves a job in a two-entry queue; the back part plays each job out at one
// result per cycle while out_stall allows, and each item gives a run of
// results: 1 for markers, fetch requests and read status, 5 or 6 for R1b, R3, R6
// and R7, 17 for the CID and CSD responses. The first result passes through the
// queue entry, the current job register and the output register. Items are taken
// every cycle while the queue has room, so the sustained rate is set by the back
// part's byte sequencer; ticks that cause no result never enter the queue.
// Depends on sdcr_pkg, sdcr_queue, sdcr_front, sdcr_back and assert_macros.svh.
`include "assert_macros.svh"
module sd_card_command_responder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sdcr_pkg::ACTION_W-1:0]   in_action,
  input  logic [sdcr_pkg::CMD_IDX_W-1:0]  in_cmd_index,
  input  logic [sdcr_pkg::ARG_W-1:0]      in_cmd_arg,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdcr_pkg::KIND_W-1:0]     out_kind,
  output logic [sdcr_pkg::FMT_W-1:0]      out_resp_format,
  output logic [sdcr_pkg::BYTE_W-1:0]     out_resp_byte,
  output logic                            out_last,
  output logic                            out_error,
  output logic [sdcr_pkg::ARG_W-1:0]      out_fetch_address,
  output logic [sdcr_pkg::LEN_W-1:0]      out_fetch_length,
  output logic                            out_read_ok,
  output logic                            out_selected
);

  sdcr_pkg::q_ctrl_t q_ctrl;
  sdcr_pkg::q_stat_t q_stat;
  sdcr_pkg::desc_t   q_wdata;
  sdcr_pkg::desc_t   q_rdata;
  logic              q_push;
  logic              q_pop;

  assign q_ctrl.push = q_push;
  assign q_ctrl.pop  = q_pop;

  sdcr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_cmd_index (in_cmd_index),
    .in_cmd_arg   (in_cmd_arg),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  sdcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .push_data (q_wdata),
    .stat      (q_stat),
    .pop_data  (q_rdata)
  );

  sdcr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_resp_format   (out_resp_format),
    .out_resp_byte     (out_resp_byte),
    .out_last          (out_last),
    .out_error         (out_error),
    .out_fetch_address (out_fetch_address),
    .out_fetch_length  (out_fetch_length),
    .out_read_ok       (out_read_ok),
    .out_selected      (out_selected)
  );

  // a job is never pushed into a full queue
  `SDCR_ASSERT_IMPLY(a_no_overflow, clk, rst_n, q_push, !q_stat.full, "queue overflow")
  // only response bytes come in runs; every other kind is a single result
  `SDCR_ASSERT_IMPLY(a_single_last, clk, rst_n,
                     out_valid && out_kind != sdcr_pkg::KIND_BYTE, out_last,
                     "non-byte result without last")
  // register responses are always byte results
  `SDCR_ASSERT_IMPLY(a_r2_bytes, clk, rst_n,
                     out_valid && out_resp_format == sdcr_pkg::FMT_R2,
                     out_kind == sdcr_pkg::KIND_BYTE && !out_error, "bad R2 result")
  // a status without a block carries no length
  `SDCR_ASSERT_IMPLY(a_empty_status, clk, rst_n,
                     out_valid && out_kind == sdcr_pkg::KIND_STATUS && !out_read_ok,
                     out_fetch_length == '0, "empty status with length")

endmodule
